// ===== hw/rtl/fbpst_pkg.sv =====
// shared types and constants for the block page status tracker
`timescale 1ns / 1ps

package fbpst_pkg;

    // field widths fixed by the stream format
    localparam int BLK_W  = 10;
    localparam int PAGE_W = 6;
    localparam int CNT_W  = 7;
    localparam int WEAR_W = 32;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 7'd64;

    // event codes carried on s_tuser
    localparam logic [1:0] ACT_PROGRAM   = 2'd0;
    localparam logic [1:0] ACT_PROG_FAIL = 2'd1;
    localparam logic [1:0] ACT_ERASE     = 2'd2;
    localparam logic [1:0] ACT_READ      = 2'd3;

    // block lifecycle codes
    localparam logic [1:0] BLK_FREE   = 2'd0;
    localparam logic [1:0] BLK_OPEN   = 2'd1;
    localparam logic [1:0] BLK_CLOSED = 2'd2;

    // read outcomes, only uncorrectable marks a page failed
    localparam logic [1:0] RD_CLEAN         = 2'd0;
    localparam logic [1:0] RD_CORRECTED     = 2'd1;
    localparam logic [1:0] RD_UNCORRECTABLE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic req_load;
        logic rd_old;
        logic rd_tgt;
        logic wr_old;
        logic wr_tgt;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic old_hit;
        logic tgt_hit;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== hw/rtl/fbpst_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fbpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fbpst_ctrl.sv =====
// sequencing state machine for the block page status tracker
`timescale 1ns / 1ps

module fbpst_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbpst_pkg::dp_sts_t  sts,
    output fbpst_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_WR_OLD,
        S_RD_TGT,
        S_WR_TGT,
        S_ZERO
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.old_hit) begin
                    cmd.rd_old = 1'b1;
                    state_next = S_WR_OLD;
                end else if (sts.tgt_hit) begin
                    cmd.rd_tgt = 1'b1;
                    state_next = S_WR_TGT;
                end else begin
                    state_next = S_ZERO;
                end
            end
            S_WR_OLD: begin
                cmd.wr_old = 1'b1;
                state_next = S_RD_TGT;
            end
            S_RD_TGT: begin
                cmd.rd_tgt = 1'b1;
                state_next = S_WR_TGT;
            end
            S_WR_TGT: begin
                if (sts.out_free) begin
                    cmd.wr_tgt   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ZERO: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // the table sweep writes nothing else and takes no request
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !in_ready && !cmd.wr_old && !cmd.wr_tgt)
        else $error("clear sweep overlaps request traffic");

    // a result is only loaded when the output register can take it
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    // the old copy update is always followed by the target read
    a_old_then_tgt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_old |=> cmd.rd_tgt)
        else $error("old copy update not followed by target read");

    // an accepted request produces nothing on the ram in the same cycle
    a_accept_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.req_load |-> !cmd.rd_old && !cmd.rd_tgt && !cmd.out_load)
        else $error("ram or output activity during accept");
`endif

endmodule

// ===== hw/rtl/fbpst_dpath.sv =====
// request, table and result datapath for the block page status tracker
`timescale 1ns / 1ps

module fbpst_dpath #(
    parameter int NUM_BLOCKS = 1024,
    parameter int MAX_PAGES  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [39:0]                   s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          cfg_valid,
    input  logic [fbpst_pkg::CFG_W-1:0]   cfg_data,
    input  fbpst_pkg::dp_cmd_t            cmd,
    output fbpst_pkg::dp_sts_t            sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = fbpst_pkg::CNT_W;
    localparam logic [fbpst_pkg::CNT_W-1:0] CNT_MAX = CW'(MAX_PAGES);

    typedef struct packed {
        logic [fbpst_pkg::WEAR_W-1:0] wear;
        logic [1:0]                   life;
        logic [fbpst_pkg::CNT_W-1:0]  ptr;
        logic [fbpst_pkg::CNT_W-1:0]  inv_cnt;
        logic [fbpst_pkg::CNT_W-1:0]  val_cnt;
        logic [MAX_PAGES-1:0]         fail_map;
        logic [MAX_PAGES-1:0]         inval_map;
        logic [MAX_PAGES-1:0]         valid_map;
    } entry_t;

    localparam int EW = $bits(entry_t);

    function automatic logic [fbpst_pkg::CNT_W-1:0] sat_inc(
        input logic [fbpst_pkg::CNT_W-1:0] v
    );
        return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic logic [MAX_PAGES-1:0] page_mask(
        input logic [fbpst_pkg::PAGE_W-1:0] p
    );
        logic [MAX_PAGES-1:0] m;
        m = '0;
        if (32'(p) < 32'(MAX_PAGES)) begin
            m = MAX_PAGES'(1) << p;
        end
        return m;
    endfunction

    // captured request
    logic [1:0]                        act_reg;
    logic [fbpst_pkg::BLK_W-1:0]       tblk_reg;
    logic [fbpst_pkg::PAGE_W-1:0]      tpage_reg;
    logic                              has_old_reg;
    logic [fbpst_pkg::BLK_W-1:0]       oblk_reg;
    logic [fbpst_pkg::PAGE_W-1:0]      opage_reg;
    logic [1:0]                        rstat_reg;

    logic [fbpst_pkg::CFG_W-1:0]       pages_in_use_reg;
    logic [AW-1:0]                     clr_cnt_reg;
    logic                              inv_flag_reg;

    logic                              out_valid_reg;
    logic [55:0]                       out_data_reg;

    logic                              tgt_in;
    logic                              old_in;
    logic [AW-1:0]                     tgt_addr;
    logic [AW-1:0]                     old_addr;

    logic [EW-1:0]                     ram_rdata;
    logic [EW-1:0]                     ram_wdata;
    logic [AW-1:0]                     ram_waddr;
    logic                              ram_we;

    entry_t                            cur_e;
    entry_t                            old_n;
    entry_t                            tgt_n;
    logic                              old_valid_hit;
    logic [MAX_PAGES-1:0]              om;
    logic [MAX_PAGES-1:0]              tm;

    assign tgt_in   = 32'(tblk_reg) < 32'(NUM_BLOCKS);
    assign old_in   = 32'(oblk_reg) < 32'(NUM_BLOCKS);
    assign tgt_addr = AW'(tblk_reg);
    assign old_addr = AW'(oblk_reg);

    assign sts.clr_last = clr_cnt_reg == AW'(NUM_BLOCKS - 1);
    assign sts.tgt_hit  = tgt_in;
    assign sts.old_hit  = tgt_in && old_in && has_old_reg &&
                          (act_reg == fbpst_pkg::ACT_PROGRAM);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign cur_e = entry_t'(ram_rdata);
    assign om    = page_mask(opage_reg);
    assign tm    = page_mask(tpage_reg);

    // old copy invalidation
    always_comb begin
        old_n         = cur_e;
        old_valid_hit = |(cur_e.valid_map & om);
        if (old_valid_hit) begin
            old_n.valid_map = cur_e.valid_map & ~om;
            old_n.inval_map = cur_e.inval_map | om;
            old_n.val_cnt   = (cur_e.val_cnt != '0) ? cur_e.val_cnt - 1'b1 : cur_e.val_cnt;
            old_n.inv_cnt   = sat_inc(cur_e.inv_cnt);
        end
    end

    // target block update
    always_comb begin
        tgt_n = cur_e;
        case (act_reg)
            fbpst_pkg::ACT_PROGRAM: begin
                tgt_n.valid_map = cur_e.valid_map | tm;
                tgt_n.inval_map = cur_e.inval_map & ~tm;
                tgt_n.fail_map  = cur_e.fail_map & ~tm;
                tgt_n.val_cnt   = sat_inc(cur_e.val_cnt);
                tgt_n.ptr       = sat_inc(cur_e.ptr);
                tgt_n.life      = (tgt_n.ptr == pages_in_use_reg) ?
                                  fbpst_pkg::BLK_CLOSED : fbpst_pkg::BLK_OPEN;
            end
            fbpst_pkg::ACT_PROG_FAIL: begin
                tgt_n.fail_map  = cur_e.fail_map | tm;
                tgt_n.valid_map = cur_e.valid_map & ~tm;
                tgt_n.inval_map = cur_e.inval_map & ~tm;
                tgt_n.ptr       = sat_inc(cur_e.ptr);
                tgt_n.life      = (tgt_n.ptr == pages_in_use_reg) ?
                                  fbpst_pkg::BLK_CLOSED : fbpst_pkg::BLK_OPEN;
            end
            fbpst_pkg::ACT_ERASE: begin
                tgt_n      = '0;
                tgt_n.life = fbpst_pkg::BLK_FREE;
                tgt_n.wear = (&cur_e.wear) ? cur_e.wear : cur_e.wear + 1'b1;
            end
            default: begin
                if (rstat_reg == fbpst_pkg::RD_UNCORRECTABLE) begin
                    tgt_n.fail_map = cur_e.fail_map | tm;
                end else begin
                    tgt_n.fail_map = cur_e.fail_map & ~tm;
                end
            end
        endcase
    end

    // ram write side: clear sweep, old copy, or target block
    always_comb begin
        ram_we    = cmd.clr_wr || cmd.wr_old || cmd.wr_tgt;
        ram_waddr = tgt_addr;
        ram_wdata = EW'(tgt_n);
        if (cmd.clr_wr) begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.wr_old) begin
            ram_waddr = old_addr;
            ram_wdata = EW'(old_n);
        end
    end

    fbpst_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_old || cmd.rd_tgt),
        .raddr (cmd.rd_old ? old_addr : tgt_addr),
        .rdata (ram_rdata)
    );

    // request and result capture, payload only
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            act_reg     <= s_tuser;
            tblk_reg    <= s_tdata[9:0];
            tpage_reg   <= s_tdata[15:10];
            has_old_reg <= s_tdata[16];
            oblk_reg    <= s_tdata[26:17];
            opage_reg   <= s_tdata[32:27];
            rstat_reg   <= s_tdata[34:33];
        end
        if (cmd.out_load) begin
            if (tgt_in) begin
                out_data_reg <= {inv_flag_reg, tgt_n.wear, tgt_n.ptr,
                                 tgt_n.inv_cnt, tgt_n.val_cnt, tgt_n.life};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_in_use_reg <= fbpst_pkg::PAGES_IN_USE_RST;
            clr_cnt_reg      <= '0;
            inv_flag_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pages_in_use_reg <= cfg_data;
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.req_load) begin
                inv_flag_reg <= 1'b0;
            end else if (cmd.wr_old) begin
                inv_flag_reg <= old_valid_hit;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // invalidation is only ever reported for a program event
    a_inv_program: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && inv_flag_reg) |-> (act_reg == fbpst_pkg::ACT_PROGRAM))
        else $error("invalidation flagged for a non-program event");

    // a pending result holds while the sink stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result changed under stall");

    // the clear sweep stops at the last block
    a_clr_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clr_wr && sts.clr_last) |=> !cmd.clr_wr)
        else $error("clear sweep ran past the last block");
`endif

endmodule

// ===== hw/rtl/flash_block_page_status_tracker_core.sv =====
// top level of the nand block page status tracker
`timescale 1ns / 1ps

// Tracks per-block NAND page status: valid, invalid and failed page bitmaps,
// valid and invalid page counts, a next-program pointer, a free/open/closed
// state and a saturating erase count, all held in one table of NUM_BLOCKS
// entries in a single ram. Each request on the s_ stream is one completion
// event (program done, program failed, erase done, read result) and yields
// exactly one result on the m_ stream describing the target block after the
// update. After reset the block sweeps the table to zero, one entry per
// cycle, over all NUM_BLOCKS entries (1024 by default); s_tready stays low
// during the sweep while configuration writes are still taken. Each
// touched block entry is read, updated and written back, since the ram has
// one read and one write port; a program that replaces an older copy in
// range handles the old entry before the target. The result sits in an
// output register, so the next request is taken while the sink holds off;
// the controller only waits if a second result is ready before the first
// has been taken. pages_in_use may only be written while no request is in
// flight.
module flash_block_page_status_tracker_core #(
    parameter int NUM_BLOCKS = 1024,
    parameter int MAX_PAGES  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    // event requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // target_block[9:0], target_page[15:10], has_old[16], prior_block[26:17],
    // old_page[32:27], read_status[34:33], zero pad[39:35]
    input  logic [39:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,

    // pages_in_use register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,

    // block status results
    output logic        m_tvalid,
    input  logic        m_tready,
    // block_state[1:0], valid_count[8:2], invalid_count[15:9],
    // next_page[22:16], wear_count[54:23], old_invalidated[55]
    output logic [55:0] m_tdata
);

    fbpst_pkg::dp_cmd_t cmd;
    fbpst_pkg::dp_sts_t sts;

    // the register is always writable
    assign cfg_ready = 1'b1;

    // sequencer: clear sweep, then one request at a time
    fbpst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // request capture, table ram, update logic and result register
    fbpst_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
